/* rtl/core/lir_pkg.sv */
`default_nettype none

package lir_pkg;

  // Default sizing of the frame and of the phase fraction.
  localparam int unsigned LirMaxFrameDef = 65536;
  localparam int unsigned LirFracBitsDef = 32;

  // Largest number of results that one source sample may release.
  localparam int unsigned LirMaxResults = 8;

  // Permitted ratio between the two rates.
  localparam int unsigned LirRatioLimit = 6;

  // Configuration port geometry.
  localparam int unsigned LirCfgAddrW = 2;
  localparam int unsigned LirCfgDataW = 17;

  // Register indexes on the configuration port.
  typedef enum logic [LirCfgAddrW-1:0] {
    CFG_SRC_RATE = 2'd0,
    CFG_DST_RATE = 2'd1,
    CFG_FRAME_LEN = 2'd2,
    CFG_UNUSED = 2'd3
  } lir_cfg_e;

  // Reset values of the registers.
  localparam logic [15:0] LirSrcRateRst = 16'd22050;
  localparam logic [15:0] LirDstRateRst = 16'd24000;
  localparam logic [16:0] LirFrameLenRst = 17'd0;

endpackage

`default_nettype wire

/* rtl/core/linear_interp_resampler.sv */
`default_nettype none

// Linear-interpolation sample-rate converter for frames of Q1.15 audio.
// Set src_rate, dst_rate and frame_length through the write port while the
// block is idle; the values are taken up on the first sample of a frame.
// Source samples enter through the input channel as valid/ready transactions
// and interpolated samples leave through the output channel, with out_last
// marking the final sample of each frame.
// All arithmetic runs through one multiplier and one radix-2 divider under a
// small sequencer, and the input is not ready while a sample is worked on.
// The first sample of a frame is first held while the block works out the
// output count and the phase step, both found by the bit-serial divider;
// with equal rates the divider is skipped and only the rate clamps are
// worked through.
// After that a sample passes through the evaluation and finish states, and
// every result that needs an interpolation adds a multiply and a round step,
// while one taken straight from the sample adds neither.
// Results wait in an output register, so the next transaction can be taken
// while the last result is still held; a stalled receiver holds the
// sequencer only when a new result is ready and the register is still full.
// Reset loads the register defaults and leaves the block idle, between
// frames, with an empty output register.
module linear_interp_resampler
  import lir_pkg::*;
#(
  parameter int unsigned MAX_FRAME = LirMaxFrameDef,
  parameter int unsigned FRAC_BITS = LirFracBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [LirCfgAddrW-1:0] cfg_addr_i,
  input  wire logic [LirCfgDataW-1:0] cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic signed [15:0]     in_sample_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic signed [15:0]          out_sample_o,
  output logic                        out_last_o
);

  // Frame count width, phase width, output count width.
  localparam int unsigned NW  = $clog2(MAX_FRAME + 1);
  localparam int unsigned PW  = NW + FRAC_BITS;
  localparam int unsigned TW  = NW + 3;
  // Shared multiplier: 16 bits by MBW bits.
  localparam int unsigned MBW = (NW > FRAC_BITS) ? NW : FRAC_BITS;
  localparam int unsigned PRW = 16 + MBW;
  // Shared divider: numerator and divisor widths.
  localparam int unsigned DNW = NW + ((FRAC_BITS > 18) ? FRAC_BITS : 18);
  localparam int unsigned DDW = (TW > 17) ? TW : 17;
  localparam int unsigned DCW = $clog2(DNW + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CLMPD = 12'b000000000010,
    S_CLMPS = 12'b000000000100,
    S_PMUL  = 12'b000000001000,
    S_DLD   = 12'b000000010000,
    S_DIV   = 12'b000000100000,
    S_TOT   = 12'b000001000000,
    S_STEP  = 12'b000010000000,
    S_EVAL  = 12'b000100000000,
    S_IMUL  = 12'b001000000000,
    S_RND   = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] cfg_src_q, cfg_src_d;
  logic [15:0] cfg_dst_q, cfg_dst_d;
  logic [16:0] cfg_len_q, cfg_len_d;

  logic signed [15:0] cur_q, cur_d;
  logic signed [15:0] prev_q, prev_d;
  logic [NW-1:0] in_cnt_q, in_cnt_d;
  logic active_q, active_d;
  logic pass_q, pass_d;
  logic [NW-1:0] n_q, n_d;
  logic [15:0] s_q, s_d;
  logic [15:0] d_q, d_d;
  logic [TW-1:0] total_q, total_d;
  logic [PW-1:0] step_q, step_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [TW-1:0] idx_q, idx_d;
  logic [3:0] cnt_q, cnt_d;

  logic [15:0] mul_a_q, mul_a_d;
  logic [MBW-1:0] mul_b_q, mul_b_d;
  logic [PRW-1:0] prod_q, prod_d;
  logic neg_q, neg_d;
  logic fin_q, fin_d;

  logic [DNW-1:0] dnum_q, dnum_d;
  logic [DDW-1:0] drem_q, drem_d;
  logic [DDW-1:0] ddiv_q, ddiv_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic dsel_q, dsel_d;

  logic signed [15:0] out_sample_q, out_sample_d;
  logic out_last_q, out_last_d;
  logic out_valid_q, out_valid_d;

  // The one multiplier of the block.
  logic [PRW-1:0] mul_p;
  assign mul_p = PRW'(mul_a_q) * PRW'(mul_b_q);

  // One restoring division step.
  logic [DDW:0] rem_sh;
  logic         rem_ge;
  logic [DDW:0] rem_sub;
  assign rem_sh  = {drem_q, dnum_q[DNW-1]};
  assign rem_ge  = rem_sh >= {1'b0, ddiv_q};
  assign rem_sub = rem_sh - {1'b0, ddiv_q};

  // Frame length, limited to the largest frame.
  logic [31:0] len_wide;
  assign len_wide = ({15'd0, cfg_len_q} > 32'(MAX_FRAME)) ? 32'(MAX_FRAME)
                                                          : {15'd0, cfg_len_q};

  // Rate clamps.
  logic [18:0] s_x6, d_x6;
  logic [15:0] s_clamped;
  assign s_x6 = ({3'd0, s_q} << 2) + ({3'd0, s_q} << 1);
  assign d_x6 = ({3'd0, d_q} << 2) + ({3'd0, d_q} << 1);
  assign s_clamped = ({3'd0, s_q} > d_x6) ? d_x6[15:0] : s_q;

  // Position of the next result.
  logic [NW-1:0]        n_m1;
  logic                 last_w;
  logic                 fin_w;
  logic [PW-1:0]        pos;
  logic [NW-1:0]        pos_k;
  logic [FRAC_BITS-1:0] pos_frac;
  logic                 more_w;
  logic                 slot_free;
  logic signed [16:0]   diff;
  logic [TW-1:0]        q_tot;

  assign n_m1      = n_q - NW'(1);
  assign last_w    = ({1'b0, in_cnt_q} + (NW+1)'(1)) >= {1'b0, n_q};
  assign fin_w     = (idx_q + TW'(1)) == total_q;
  assign pos       = fin_w ? (PW'(n_m1) << FRAC_BITS) : acc_q;
  assign pos_k     = pos[PW-1:FRAC_BITS];
  assign pos_frac  = pos[FRAC_BITS-1:0];
  assign more_w    = (idx_q < total_q) && (cnt_q < 4'(LirMaxResults));
  assign slot_free = !out_valid_q || out_ready_i;
  assign diff      = 17'(cur_q) - 17'(prev_q);
  assign q_tot     = dnum_q[TW-1:0];

  // Rounding of the interpolated step and saturation.
  logic [PRW:0]       rnd_sum;
  logic [16:0]        rnd_mag;
  logic signed [17:0] rnd_val;
  logic signed [15:0] rnd_sat;
  assign rnd_sum = {1'b0, prod_q} + ((PRW+1)'(1) << (FRAC_BITS - 1));
  assign rnd_mag = 17'(rnd_sum >> FRAC_BITS);
  assign rnd_val = neg_q ? (18'(prev_q) - 18'(rnd_mag)) : (18'(prev_q) + 18'(rnd_mag));
  always_comb begin
    if (rnd_val > 18'sd32767) begin
      rnd_sat = 16'sh7fff;
    end else if (rnd_val < -18'sd32768) begin
      rnd_sat = -16'sh8000;
    end else begin
      rnd_sat = rnd_val[15:0];
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_last_o   = out_last_q;

  always_comb begin
    state_d      = state_q;
    cfg_src_d    = cfg_src_q;
    cfg_dst_d    = cfg_dst_q;
    cfg_len_d    = cfg_len_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    in_cnt_d     = in_cnt_q;
    active_d     = active_q;
    pass_d       = pass_q;
    n_d          = n_q;
    s_d          = s_q;
    d_d          = d_q;
    total_d      = total_q;
    step_d       = step_q;
    acc_d        = acc_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    mul_a_d      = mul_a_q;
    mul_b_d      = mul_b_q;
    prod_d       = prod_q;
    neg_d        = neg_q;
    fin_d        = fin_q;
    dnum_d       = dnum_q;
    drem_d       = drem_q;
    ddiv_d       = ddiv_q;
    dcnt_d       = dcnt_q;
    dsel_d       = dsel_q;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (cfg_we_i) begin
      case (lir_cfg_e'(cfg_addr_i))
        CFG_SRC_RATE:  cfg_src_d = cfg_wdata_i[15:0];
        CFG_DST_RATE:  cfg_dst_d = cfg_wdata_i[15:0];
        CFG_FRAME_LEN: cfg_len_d = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_d = in_sample_i;
          cnt_d = '0;
          if (active_q) begin
            state_d = S_EVAL;
          end else if (cfg_len_q != '0) begin
            // A new frame takes up the current register values.
            s_d      = (cfg_src_q == '0) ? 16'd1 : cfg_src_q;
            d_d      = (cfg_dst_q == '0) ? 16'd1 : cfg_dst_q;
            n_d      = len_wide[NW-1:0];
            active_d = 1'b1;
            state_d  = S_CLMPD;
          end
        end
      end
      S_CLMPD: begin
        if ({3'd0, d_q} > s_x6) begin
          d_d = s_x6[15:0];
        end
        state_d = S_CLMPS;
      end
      S_CLMPS: begin
        s_d     = s_clamped;
        pass_d  = (s_clamped == d_q);
        mul_a_d = d_q;
        mul_b_d = MBW'(n_m1);
        state_d = (s_clamped == d_q) ? S_EVAL : S_PMUL;
      end
      S_PMUL: begin
        prod_d  = mul_p;
        state_d = S_DLD;
      end
      S_DLD: begin
        // Output count: round((n-1)*dst/src) by (2*(n-1)*dst + src) / (2*src).
        dnum_d  = (DNW'(prod_q[NW+15:0]) << 1) + DNW'(s_q);
        ddiv_d  = DDW'({s_q, 1'b0});
        drem_d  = '0;
        dcnt_d  = DCW'(DNW);
        dsel_d  = 1'b0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (rem_ge) begin
          drem_d = rem_sub[DDW-1:0];
        end else begin
          drem_d = rem_sh[DDW-1:0];
        end
        dnum_d = {dnum_q[DNW-2:0], rem_ge};
        dcnt_d = dcnt_q - DCW'(1);
        if (dcnt_q == DCW'(1)) begin
          state_d = dsel_q ? S_STEP : S_TOT;
        end
      end
      S_TOT: begin
        // At least two results per frame; the step divides by count-1.
        total_d = (q_tot == '0) ? TW'(2) : (q_tot + TW'(1));
        dnum_d  = DNW'(PW'(n_m1) << FRAC_BITS);
        ddiv_d  = DDW'((q_tot == '0) ? TW'(1) : q_tot);
        drem_d  = '0;
        dcnt_d  = DCW'(DNW);
        dsel_d  = 1'b1;
        state_d = S_DIV;
      end
      S_STEP: begin
        step_d  = dnum_q[PW-1:0];
        acc_d   = '0;
        idx_d   = '0;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (pass_q) begin
          if (slot_free) begin
            out_sample_d = cur_q;
            out_last_d   = last_w;
            out_valid_d  = 1'b1;
            state_d      = S_FIN;
          end
        end else if (!more_w) begin
          state_d = S_FIN;
        end else if (pos_k < in_cnt_q) begin
          mul_a_d = diff[16] ? 16'(-diff) : diff[15:0];
          mul_b_d = MBW'(pos_frac);
          neg_d   = diff[16];
          fin_d   = fin_w;
          state_d = S_IMUL;
        end else if (last_w) begin
          // Right neighbour clamped to the last sample of the frame.
          if (slot_free) begin
            out_sample_d = cur_q;
            out_last_d   = fin_w;
            out_valid_d  = 1'b1;
            acc_d        = acc_q + step_q;
            idx_d        = idx_q + TW'(1);
            cnt_d        = cnt_q + 4'd1;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_IMUL: begin
        prod_d  = mul_p;
        state_d = S_RND;
      end
      S_RND: begin
        if (slot_free) begin
          out_sample_d = rnd_sat;
          out_last_d   = fin_q;
          out_valid_d  = 1'b1;
          acc_d        = acc_q + step_q;
          idx_d        = idx_q + TW'(1);
          cnt_d        = cnt_q + 4'd1;
          state_d      = S_EVAL;
        end
      end
      S_FIN: begin
        prev_d = cur_q;
        if (last_w) begin
          in_cnt_d = '0;
          active_d = 1'b0;
        end else begin
          in_cnt_d = in_cnt_q + NW'(1);
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_src_q   <= LirSrcRateRst;
      cfg_dst_q   <= LirDstRateRst;
      cfg_len_q   <= LirFrameLenRst;
      prev_q      <= '0;
      in_cnt_q    <= '0;
      active_q    <= 1'b0;
      pass_q      <= 1'b0;
      total_q     <= '0;
      step_q      <= '0;
      acc_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      dsel_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_src_q   <= cfg_src_d;
      cfg_dst_q   <= cfg_dst_d;
      cfg_len_q   <= cfg_len_d;
      prev_q      <= prev_d;
      in_cnt_q    <= in_cnt_d;
      active_q    <= active_d;
      pass_q      <= pass_d;
      total_q     <= total_d;
      step_q      <= step_d;
      acc_q       <= acc_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
      dsel_q      <= dsel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and operand registers.
  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    n_q          <= n_d;
    s_q          <= s_d;
    d_q          <= d_d;
    mul_a_q      <= mul_a_d;
    mul_b_q      <= mul_b_d;
    prod_q       <= prod_d;
    neg_q        <= neg_d;
    fin_q        <= fin_d;
    dnum_q       <= dnum_d;
    drem_q       <= drem_d;
    ddiv_q       <= ddiv_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

endmodule

`default_nettype wire
